// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check an expression on the clock edge after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/kvi_pkg.sv
// ----------------------------------------------------------------------------
// kvi_pkg
// Constants, types and the normal ROM for the keyframe vertex interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

    localparam int NORMAL_COUNT_DEF = 162;
    localparam int ROM_DEPTH        = 162;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 48;
    localparam int IN_TDATA_W       = 104;
    localparam int OUT_TDATA_W      = 152;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FIRST   = 3'd0,
        REG_OFFSET_FIRST  = 3'd1,
        REG_SCALE_SECOND  = 3'd2,
        REG_OFFSET_SECOND = 3'd3,
        REG_BLEND_WEIGHT  = 3'd4
    } t_cfg_reg;

    typedef logic signed [15:0] t_nvec [3];

    localparam logic signed [15:0] C5257 = 16'sd8614;
    localparam logic signed [15:0] C8507 = 16'sd13937;
    localparam logic signed [15:0] C4429 = 16'sd7256;
    localparam logic signed [15:0] C2389 = 16'sd3913;
    localparam logic signed [15:0] C8642 = 16'sd14159;
    localparam logic signed [15:0] C2952 = 16'sd4837;
    localparam logic signed [15:0] C9554 = 16'sd15654;
    localparam logic signed [15:0] C3090 = 16'sd5063;
    localparam logic signed [15:0] C5000 = 16'sd8192;
    localparam logic signed [15:0] C8090 = 16'sd13255;
    localparam logic signed [15:0] C1625 = 16'sd2662;
    localparam logic signed [15:0] C2629 = 16'sd4307;
    localparam logic signed [15:0] C9511 = 16'sd15582;
    localparam logic signed [15:0] C1476 = 16'sd2419;
    localparam logic signed [15:0] C7166 = 16'sd11740;
    localparam logic signed [15:0] C6817 = 16'sd11169;
    localparam logic signed [15:0] C5878 = 16'sd9630;
    localparam logic signed [15:0] C4253 = 16'sd6969;
    localparam logic signed [15:0] C6882 = 16'sd11275;
    localparam logic signed [15:0] C1000 = 16'sd16384;
    localparam logic signed [15:0] Z     = 16'sd0;

    localparam logic signed [15:0] NROM [ROM_DEPTH*3] = '{
        -C5257,Z,C8507, -C4429,C2389,C8642, -C2952,Z,C9554, -C3090,C5000,C8090,
        -C1625,C2629,C9511, Z,Z,C1000, Z,C8507,C5257, -C1476,C7166,C6817,
        C1476,C7166,C6817, Z,C5257,C8507, C3090,C5000,C8090, C5257,Z,C8507,
        C2952,Z,C9554, C4429,C2389,C8642, C1625,C2629,C9511, -C6817,C1476,C7166,
        -C8090,C3090,C5000, -C5878,C4253,C6882, -C8507,C5257,Z, -C8642,C4429,C2389,
        -C7166,C6817,C1476, -C6882,C5878,C4253, -C5000,C8090,C3090,
        -C2389,C8642,C4429,
        -C4253,C6882,C5878, -C7166,C6817,-C1476, -C5000,C8090,-C3090, -C5257,C8507,Z,
        Z,C8507,-C5257, -C2389,C8642,-C4429, Z,C9554,-C2952, -C2629,C9511,-C1625,
        Z,C1000,Z, Z,C9554,C2952, -C2629,C9511,C1625, C2389,C8642,C4429,
        C2629,C9511,C1625, C5000,C8090,C3090, C2389,C8642,-C4429, C2629,C9511,-C1625,
        C5000,C8090,-C3090, C8507,C5257,Z, C7166,C6817,C1476, C7166,C6817,-C1476,
        C5257,C8507,Z, C4253,C6882,C5878, C8642,C4429,C2389, C6882,C5878,C4253,
        C8090,C3090,C5000, C6817,C1476,C7166, C5878,C4253,C6882, C9554,C2952,Z,
        C1000,Z,Z, C9511,C1625,C2629, C8507,-C5257,Z, C9554,-C2952,Z,
        C8642,-C4429,C2389, C9511,-C1625,C2629, C8090,-C3090,C5000, C6817,-C1476,C7166,
        C8507,Z,C5257, C8642,C4429,-C2389, C8090,C3090,-C5000, C9511,C1625,-C2629,
        C5257,Z,-C8507, C6817,C1476,-C7166, C6817,-C1476,-C7166, C8507,Z,-C5257,
        C8090,-C3090,-C5000, C8642,-C4429,-C2389, C9511,-C1625,-C2629,
        C1476,C7166,-C6817,
        C3090,C5000,-C8090, C4253,C6882,-C5878, C4429,C2389,-C8642, C5878,C4253,-C6882,
        C6882,C5878,-C4253, -C1476,C7166,-C6817, -C3090,C5000,-C8090, Z,C5257,-C8507,
        -C5257,Z,-C8507, -C4429,C2389,-C8642, -C2952,Z,-C9554, -C1625,C2629,-C9511,
        Z,Z,-C1000, C2952,Z,-C9554, C1625,C2629,-C9511, -C4429,-C2389,-C8642,
        -C3090,-C5000,-C8090, -C1625,-C2629,-C9511, Z,-C8507,-C5257,
        -C1476,-C7166,-C6817,
        C1476,-C7166,-C6817, Z,-C5257,-C8507, C3090,-C5000,-C8090, C4429,-C2389,-C8642,
        C1625,-C2629,-C9511, C2389,-C8642,-C4429, C5000,-C8090,-C3090,
        C4253,-C6882,-C5878,
        C7166,-C6817,-C1476, C6882,-C5878,-C4253, C5878,-C4253,-C6882, Z,-C9554,-C2952,
        Z,-C1000,Z, C2629,-C9511,-C1625, Z,-C8507,C5257, Z,-C9554,C2952,
        C2389,-C8642,C4429, C2629,-C9511,C1625, C5000,-C8090,C3090, C7166,-C6817,C1476,
        C5257,-C8507,Z, -C2389,-C8642,-C4429, -C5000,-C8090,-C3090,
        -C2629,-C9511,-C1625,
        -C8507,-C5257,Z, -C7166,-C6817,-C1476, -C7166,-C6817,C1476, -C5257,-C8507,Z,
        -C5000,-C8090,C3090, -C2389,-C8642,C4429, -C2629,-C9511,C1625,
        -C8642,-C4429,C2389,
        -C8090,-C3090,C5000, -C6882,-C5878,C4253, -C6817,-C1476,C7166,
        -C4429,-C2389,C8642,
        -C5878,-C4253,C6882, -C3090,-C5000,C8090, -C1476,-C7166,C6817,
        -C4253,-C6882,C5878,
        -C1625,-C2629,C9511, C4429,-C2389,C8642, C1625,-C2629,C9511, C3090,-C5000,C8090,
        C1476,-C7166,C6817, Z,-C5257,C8507, C4253,-C6882,C5878, C5878,-C4253,C6882,
        C6882,-C5878,C4253, -C9554,C2952,Z, -C9511,C1625,C2629, -C1000,Z,Z,
        -C8507,Z,C5257, -C9554,-C2952,Z, -C9511,-C1625,C2629, -C8642,C4429,-C2389,
        -C9511,C1625,-C2629, -C8090,C3090,-C5000, -C8642,-C4429,-C2389,
        -C9511,-C1625,-C2629,
        -C8090,-C3090,-C5000, -C6817,C1476,-C7166, -C6817,-C1476,-C7166,
        -C8507,Z,-C5257,
        -C6882,C5878,-C4253, -C5878,C4253,-C6882, -C4253,C6882,-C5878,
        -C4253,-C6882,-C5878,
        -C5878,-C4253,-C6882, -C6882,-C5878,-C4253
    };

endpackage

// File: rtl/keyframe_vertex_interpolator_unit.sv
// An input passes the decode, difference, product and output registers in order.
// Throughput: one vertex per cycle; the four-stage pipeline advances whenever
// the output register is empty or is being taken, so a stall holds every stage.
// Reset: synchronous active-low i_rst_n clears the valid bits and all
// configuration registers (scales, offsets and weight read as zero).
// ----------------------------------------------------------------------------
// keyframe_vertex_interpolator_unit
// Decodes two keyframe positions and normals and blends them by one weight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyframe_vertex_interpolator_unit
    import kvi_pkg::*;
#(
    parameter int NORMAL_COUNT = NORMAL_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // first_x, first_y, first_z, first_normal, second_x, second_y, second_z,
    // second_normal, tex_s_in, tex_t_in, then zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_s_out, tex_t_out,
    // then zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [7:0] IDX_MAX = 8'(((NORMAL_COUNT < ROM_DEPTH) ? NORMAL_COUNT
                                                                   : ROM_DEPTH) - 1);

    logic [47:0] r_scale1, r_off1, r_scale2, r_off2;
    logic [16:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale1 <= '0;
            r_off1   <= '0;
            r_scale2 <= '0;
            r_off2   <= '0;
            r_weight <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE_FIRST:   r_scale1 <= i_cfg_data;
                REG_OFFSET_FIRST:  r_off1   <= i_cfg_data;
                REG_SCALE_SECOND:  r_scale2 <= i_cfg_data;
                REG_OFFSET_SECOND: r_off2   <= i_cfg_data;
                REG_BLEND_WEIGHT:  r_weight <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic [16:0] w_eff;
    assign w_eff = (r_weight > ONE_Q16) ? ONE_Q16 : r_weight;

    logic r_v1, r_v2, r_v3, r_v4;
    logic adv;
    assign adv = !r_v4 || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 1: decode positions, look up normals
    logic signed [25:0] r_p1 [3], r_p2 [3];
    logic signed [15:0] r_na [3], r_nb [3];
    logic [16:0] r1_s, r1_t;
    // stage 2: differences
    logic signed [25:0] r2_p1 [3];
    logic signed [26:0] r2_d [3];
    logic signed [15:0] r2_n1 [3];
    logic signed [16:0] r2_dn [3];
    logic [16:0] r2_s, r2_t;
    // stage 3: products
    logic signed [43:0] r3_acc [3];
    logic signed [32:0] r3_nacc [3];
    logic [16:0] r3_s, r3_t;
    // stage 4: output register
    logic signed [22:0] r4_pos [3];
    logic signed [15:0] r4_n [3];
    logic [16:0] r4_s, r4_t;

    logic [7:0] i_b1 [3], i_b2 [3];
    logic [7:0] idx1, idx2;
    assign i_b1[0] = s_axis_tdata[7:0];
    assign i_b1[1] = s_axis_tdata[15:8];
    assign i_b1[2] = s_axis_tdata[23:16];
    assign i_b2[0] = s_axis_tdata[39:32];
    assign i_b2[1] = s_axis_tdata[47:40];
    assign i_b2[2] = s_axis_tdata[55:48];
    assign idx1 = (s_axis_tdata[31:24] > IDX_MAX) ? IDX_MAX : s_axis_tdata[31:24];
    assign idx2 = (s_axis_tdata[63:56] > IDX_MAX) ? IDX_MAX : s_axis_tdata[63:56];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                r_p1[a] <= $signed({2'b00, 24'(r_scale1[16*a +: 16]) * 24'(i_b1[a])})
                         + 26'(signed'({r_off1[16*a +: 16], 4'b0000}));
                r_p2[a] <= $signed({2'b00, 24'(r_scale2[16*a +: 16]) * 24'(i_b2[a])})
                         + 26'(signed'({r_off2[16*a +: 16], 4'b0000}));
                r_na[a] <= NROM[9'(3 * idx1 + a)];
                r_nb[a] <= NROM[9'(3 * idx2 + a)];
            end
            r1_s <= s_axis_tdata[80:64];
            r1_t <= s_axis_tdata[97:81];

            for (int a = 0; a < 3; a++) begin
                r2_p1[a] <= r_p1[a];
                r2_d[a]  <= 27'(r_p2[a]) - 27'(r_p1[a]);
                r2_n1[a] <= r_na[a];
                r2_dn[a] <= 17'(r_nb[a]) - 17'(r_na[a]);
            end
            r2_s <= r1_s;
            r2_t <= (r1_t >= ONE_Q16) ? 17'd0 : ONE_Q16 - r1_t;

            for (int a = 0; a < 3; a++) begin
                r3_acc[a]  <= $signed({r2_p1[a], 16'd0}) + r2_d[a] * $signed({1'b0, w_eff})
                            + 44'sd524288;
                r3_nacc[a] <= $signed({r2_n1[a], 16'd0}) + r2_dn[a] * $signed({1'b0, w_eff})
                            + 33'sd32768;
            end
            r3_s <= r2_s;
            r3_t <= r2_t;

            for (int a = 0; a < 3; a++) begin
                r4_pos[a] <= r3_acc[a][42:20];
                r4_n[a]   <= r3_nacc[a][31:16];
            end
            r4_s <= r3_s;
            r4_t <= r3_t;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {1'b0, r4_t, r4_s, r4_n[2], r4_n[1], r4_n[0],
                            r4_pos[2], r4_pos[1], r4_pos[0]};

    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_v4 && !m_axis_tready, r_v4 && $stable(r_v3),
                 "pipeline moved while the output stalled")
    `ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !r_v4, s_axis_tready,
                 "input blocked with an empty output register")
    `ASSERT_NEXT(a_flow, i_clk, i_rst_n, adv && r_v3, r_v4,
                 "valid lost between stage three and output")

endmodule
